// ===== src/twt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twt_pkg: shared types and constants of the trapped water total unit
// Word formats, controller states and the command/status groups that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package twt_pkg;

	localparam int TWT_MAX_BARS    = 1024;
	localparam int TWT_HEIGHT_BITS = 30;
	localparam int BAR_FIELD_BITS  = 30;
	localparam int WATER_BITS      = 40;

	typedef struct packed {
		logic [BAR_FIELD_BITS-1:0] bar_height;
		logic                      last_bar;
	} in_word_t;

	typedef struct packed {
		logic [WATER_BITS-1:0] water_sum;
		logic                  overflowed;
	} out_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INIT,
		ST_WALK,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic init;
		logic step;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic walk_done;
	} status_t;

endpackage

// ===== src/twt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twt_datapath: bar store, pointers, peaks and water accumulator
// Stores bars, then performs one two-pointer step per cycle on command.
// ----------------------------------------------------------------------------
module twt_datapath #(
	parameter int MAX_BARS    = twt_pkg::TWT_MAX_BARS,
	parameter int HEIGHT_BITS = twt_pkg::TWT_HEIGHT_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  twt_pkg::cmd_t       cmd,
	input  twt_pkg::in_word_t   bar,
	output twt_pkg::status_t    status,
	output twt_pkg::out_word_t  result
);
	import twt_pkg::*;

	localparam int IW = $clog2(MAX_BARS);
	localparam int CW = $clog2(MAX_BARS + 1);

	logic [HEIGHT_BITS-1:0] mem [MAX_BARS];

	logic [CW-1:0]          count_q;
	logic                   drop_q;
	logic [IW-1:0]          li_q, ri_q, li_d, ri_d;
	logic [HEIGHT_BITS-1:0] lp_q, rp_q;
	logic [HEIGHT_BITS-1:0] lh_q, rh_q;
	logic [WATER_BITS-1:0]  acc_q;

	logic [HEIGHT_BITS+BAR_FIELD_BITS-1:0] h_ext;
	logic [HEIGHT_BITS-1:0] h;
	logic                   full;
	logic [CW-1:0]          last_idx;
	logic                   go_left;
	logic                   raise;
	logic [HEIGHT_BITS-1:0] amount;
	logic [WATER_BITS:0]    sum;

	assign h_ext    = (HEIGHT_BITS + BAR_FIELD_BITS)'(bar.bar_height);
	assign h        = h_ext[HEIGHT_BITS-1:0];
	assign full     = (count_q == CW'(MAX_BARS));
	assign last_idx = count_q - CW'(1);

	assign status.walk_done = !(li_q < ri_q);

	// lower bar side advances; a tie advances the right side
	assign go_left = (lh_q < rh_q);
	assign raise   = go_left ? (lh_q >= lp_q) : (rh_q >= rp_q);
	assign amount  = go_left ? (lp_q - lh_q) : (rp_q - rh_q);
	assign sum     = {1'b0, acc_q} + (WATER_BITS + 1)'(amount);

	always_comb begin
		li_d = li_q;
		ri_d = ri_q;
		if (cmd.init) begin
			li_d = '0;
			ri_d = last_idx[IW-1:0];
		end else if (cmd.step) begin
			if (go_left) begin
				li_d = li_q + IW'(1);
			end else begin
				ri_d = ri_q - IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && !full) begin
			mem[count_q[IW-1:0]] <= h;
		end
		lh_q <= mem[li_d];
		rh_q <= mem[ri_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			drop_q  <= 1'b0;
			li_q    <= '0;
			ri_q    <= '0;
			lp_q    <= '0;
			rp_q    <= '0;
			acc_q   <= '0;
		end else begin
			li_q <= li_d;
			ri_q <= ri_d;
			if (cmd.clear) begin
				count_q <= '0;
				drop_q  <= 1'b0;
			end else if (cmd.load) begin
				if (full) begin
					drop_q <= 1'b1;
				end else begin
					count_q <= count_q + CW'(1);
				end
			end
			if (cmd.init) begin
				lp_q  <= '0;
				rp_q  <= '0;
				acc_q <= '0;
			end else if (cmd.step) begin
				if (raise) begin
					if (go_left) begin
						lp_q <= lh_q;
					end else begin
						rp_q <= rh_q;
					end
				end else if (sum[WATER_BITS]) begin
					acc_q <= '1;
				end else begin
					acc_q <= sum[WATER_BITS-1:0];
				end
			end
		end
	end

	assign result.water_sum  = acc_q;
	assign result.overflowed = drop_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (li_q < ri_q))
		else $error("step issued with pointers already met");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && full) |=> drop_q)
		else $error("drop flag not set on bar beyond store depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> (li_q <= ri_q))
		else $error("pointers crossed");

endmodule

// ===== src/twt_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twt_controller: sequencing of load, walk and result
// Accepts bar words, starts the walk on the last bar and strobes the result.
// ----------------------------------------------------------------------------
module twt_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              last_bar,
	input  twt_pkg::status_t  status,
	output twt_pkg::cmd_t     cmd,
	output logic              busy,
	output logic              done
);
	import twt_pkg::*;

	state_t state_q, state_d;
	logic   accept;

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && last_bar) begin
					state_d = ST_INIT;
				end
			end
			ST_INIT: state_d = ST_WALK;
			ST_WALK: begin
				if (status.walk_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd   = '0;
		busy  = 1'b1;
		done  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_INIT: cmd.init = 1'b1;
			ST_WALK: cmd.step = !status.walk_done;
			ST_EMIT: begin
				done      = 1'b1;
				cmd.clear = 1'b1;
			end
			default: begin
				cmd  = '0;
				busy = 1'b1;
			end
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !last_bar) |=> !busy)
		else $error("busy after a non-final bar");
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_bar) |=> busy)
		else $error("walk not started on final bar");
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobed while idle");

endmodule

// ===== src/trapped_water_total_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapped_water_total_unit: rain water trapped by an elevation profile
// Loads bar heights into a store, walks it with two pointers and emits the
// saturated water total with a flag for dropped bars.
// ----------------------------------------------------------------------------
//
//  channel   signals               direction  handshake
//  --------  --------------------  ---------  ------------------------------
//  bar word  start, busy, bar      in         taken when start && !busy
//  result    done, result          out        one-cycle strobe, no back-off
//
//  A non-final bar leaves busy low, and the next bar may follow in the
//  next cycle.
//  After the final bar busy stays high through ST_INIT, which primes the two
//  store read ports, ST_WALK, the pointer walk (one step per cycle, set by
//  the dual-read bar store), and ST_EMIT, the result state.
//  done is high for the single cycle of ST_EMIT; the receiver cannot stall it.
//  Reset clears counts, pointers, peaks, total and the drop flag; the bar
//  store itself is not cleared, as only entries written in a profile are read.
//
module trapped_water_total_unit #(
	parameter int MAX_BARS    = twt_pkg::TWT_MAX_BARS,
	parameter int HEIGHT_BITS = twt_pkg::TWT_HEIGHT_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  twt_pkg::in_word_t   bar,
	output logic                done,
	output twt_pkg::out_word_t  result
);
	import twt_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequence load, walk and result
	twt_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.last_bar (bar.last_bar),
		.status   (status),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done)
	);

	// hold the store and advance the walk
	twt_datapath #(
		.MAX_BARS    (MAX_BARS),
		.HEIGHT_BITS (HEIGHT_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.bar    (bar),
		.status (status),
		.result (result)
	);

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for trapped_water_total_unit
// Feeds elevation profiles one bar word at a time and predicts the trapped
// water total and drop flag of each profile with an independent two-pointer
// walk. Every result strobe is compared field by field with the oldest
// expectation. The run covers short directed profiles, then random profiles
// under several sender idling regimes and a full store that overflows.
// ----------------------------------------------------------------------------

import twt_pkg::*;

// Scoreboard: mirrors the bar store, computes the expected total when a final
// bar is taken and checks each result word against the oldest expectation.
class water_scoreboard;
	localparam logic [BAR_FIELD_BITS-1:0] HEIGHT_MASK =
		BAR_FIELD_BITS'((64'd1 << TWT_HEIGHT_BITS) - 64'd1);
	localparam logic [WATER_BITS:0] WATER_CEIL = (41'd1 << WATER_BITS) - 41'd1;

	logic [BAR_FIELD_BITS-1:0] heights [TWT_MAX_BARS];
	int unsigned stored;
	bit          dropped;
	out_word_t   expected_totals [$];
	int unsigned errors;
	int unsigned profiles_checked;
	int unsigned overflow_profiles;
	int unsigned longest_profile;
	int unsigned profile_len;

	function new();
		stored = 0;
		dropped = 0;
		errors = 0;
		profiles_checked = 0;
		overflow_profiles = 0;
		longest_profile = 0;
		profile_len = 0;
	endfunction

	task flag_mismatch(string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	function int unsigned pending();
		return expected_totals.size();
	endfunction

	// Two-pointer walk over the stored bars; ties advance the right side.
	function void settle_profile();
		int unsigned lo;
		int unsigned hi;
		logic [BAR_FIELD_BITS-1:0] lpeak;
		logic [BAR_FIELD_BITS-1:0] rpeak;
		logic [BAR_FIELD_BITS-1:0] lh;
		logic [BAR_FIELD_BITS-1:0] rh;
		logic [WATER_BITS:0] total;
		out_word_t want;
		lo = 0;
		hi = (stored > 0) ? stored - 1 : 0;
		lpeak = '0;
		rpeak = '0;
		total = '0;
		while (lo < hi) begin
			lh = heights[lo];
			rh = heights[hi];
			if (lh < rh) begin
				if (lh >= lpeak)
					lpeak = lh;
				else
					total = total + (lpeak - lh);
				lo++;
			end else begin
				if (rh >= rpeak)
					rpeak = rh;
				else
					total = total + (rpeak - rh);
				hi--;
			end
			if (total > WATER_CEIL)
				total = WATER_CEIL;
		end
		want.water_sum  = total[WATER_BITS-1:0];
		want.overflowed = dropped;
		expected_totals.push_back(want);
		if (dropped)
			overflow_profiles++;
		if (profile_len > longest_profile)
			longest_profile = profile_len;
		stored = 0;
		dropped = 0;
		profile_len = 0;
	endfunction

	function void note_bar(in_word_t w);
		profile_len++;
		if (stored < TWT_MAX_BARS) begin
			heights[stored] = w.bar_height & HEIGHT_MASK;
			stored++;
		end else begin
			dropped = 1;
		end
		if (w.last_bar)
			settle_profile();
	endfunction

	task check_result(out_word_t got);
		out_word_t want;
		if (expected_totals.size() == 0) begin
			flag_mismatch($sformatf("result %0d/%0b with no profile waiting",
				got.water_sum, got.overflowed));
		end else begin
			want = expected_totals.pop_front();
			profiles_checked++;
			if (got.water_sum !== want.water_sum)
				flag_mismatch($sformatf("water_sum got %0d want %0d",
					got.water_sum, want.water_sum));
			if (got.overflowed !== want.overflowed)
				flag_mismatch($sformatf("overflowed got %0b want %0b",
					got.overflowed, want.overflowed));
		end
	endtask
endclass

module tb_top;

	localparam int          LIMIT_CYCLES = 600000;
	localparam int          SETTLE_CYCLES = 40;
	localparam logic [BAR_FIELD_BITS-1:0] TOP_HEIGHT =
		BAR_FIELD_BITS'((64'd1 << TWT_HEIGHT_BITS) - 64'd1);

	// Height styles for random profiles
	localparam int STYLE_LOW     = 0;	// many ties and shallow pools
	localparam int STYLE_FULL    = 1;	// full 30-bit range
	localparam int STYLE_EXTREME = 2;	// mostly floor and ceiling

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	logic      busy;
	in_word_t  bar = '0;
	logic      done;
	out_word_t result;

	water_scoreboard sb;
	in_word_t        bar_words [$];
	int unsigned     words_queued = 0;
	int unsigned     words_taken = 0;
	int unsigned     idle_pct = 0;
	int unsigned     calm_left = 0;
	int unsigned     cycle_count = 0;

	trapped_water_total_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.bar    (bar),
		.done   (done),
		.result (result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Sender: a word is taken on an edge with start high and busy low. Hold the
	// word while busy; otherwise offer the next one or idle at random. Calm
	// stretches switch idling off now and then so back-to-back words occur
	// in every regime.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				sb.note_bar(bar);
				words_taken++;
			end
			if (!start || !busy) begin
				if (calm_left > 0)
					calm_left--;
				else if ($urandom_range(49) == 0)
					calm_left = $urandom_range(40, 10);
				if (bar_words.size() > 0 && (calm_left > 0 || $urandom_range(99) >= idle_pct)) begin
					start <= 1'b1;
					bar   <= bar_words.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Receiver: results cannot be held off, so check every strobe as it comes.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	// Watchdog: drop the run if it hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("** trapped_water_total_unit: FAILED **");
			$finish;
		end
	end

	task queue_bar(logic [BAR_FIELD_BITS-1:0] h, logic last);
		in_word_t w;
		w.bar_height = h;
		w.last_bar   = last;
		bar_words.push_back(w);
		words_queued++;
	endtask

	task queue_profile(int unsigned len, int style);
		logic [BAR_FIELD_BITS-1:0] h;
		for (int unsigned i = 0; i < len; i++) begin
			case (style)
				STYLE_LOW: begin
					h = BAR_FIELD_BITS'($urandom_range(7));
				end
				STYLE_EXTREME: begin
					case ($urandom_range(3))
						0, 1: h = '0;
						2: h = TOP_HEIGHT;
						default: h = BAR_FIELD_BITS'($urandom);
					endcase
				end
				default: begin
					h = BAR_FIELD_BITS'($urandom);
				end
			endcase
			queue_bar(h, i == len - 1);
		end
	endtask

	// Deepest basin the store allows: two ceiling walls around a flat floor,
	// then extra bars beyond the store depth, the final one among them.
	task queue_full_basin(int unsigned extra);
		queue_bar(TOP_HEIGHT, 1'b0);
		for (int i = 0; i < TWT_MAX_BARS - 2; i++)
			queue_bar('0, 1'b0);
		queue_bar(TOP_HEIGHT, extra == 0);
		for (int unsigned i = 0; i < extra; i++)
			queue_bar(BAR_FIELD_BITS'($urandom), i == extra - 1);
	endtask

	task queue_random_mix(int unsigned target);
		int unsigned goal;
		int unsigned len;
		int unsigned pick;
		goal = words_queued + target;
		while (words_queued < goal) begin
			pick = $urandom_range(99);
			if (pick < 88)
				len = $urandom_range(16, 1);
			else if (pick < 98)
				len = $urandom_range(64, 17);
			else
				len = $urandom_range(128, 65);
			queue_profile(len, $urandom_range(STYLE_EXTREME));
		end
	endtask

	// Let the sender drain its queue and every result come back.
	task drain_phase();
		while (words_taken != words_queued || start)
			@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: single bars at floor and ceiling, a two-bar edge, a full
		// ceiling pool, a tie, and the textbook profile.
		idle_pct = 0;
		queue_bar('0, 1'b1);
		queue_bar(TOP_HEIGHT, 1'b1);
		queue_bar(TOP_HEIGHT, 1'b0);
		queue_bar('0, 1'b1);
		queue_bar(TOP_HEIGHT, 1'b0);
		queue_bar('0, 1'b0);
		queue_bar(TOP_HEIGHT, 1'b1);
		queue_bar(30'd2, 1'b0);
		queue_bar(30'd0, 1'b0);
		queue_bar(30'd2, 1'b1);
		queue_bar(30'd0, 1'b0);
		queue_bar(30'd1, 1'b0);
		queue_bar(30'd0, 1'b0);
		queue_bar(30'd2, 1'b0);
		queue_bar(30'd1, 1'b0);
		queue_bar(30'd0, 1'b0);
		queue_bar(30'd1, 1'b0);
		queue_bar(30'd3, 1'b0);
		queue_bar(30'd2, 1'b0);
		queue_bar(30'd1, 1'b0);
		queue_bar(30'd2, 1'b0);
		queue_bar(30'd1, 1'b1);
		drain_phase();

		// Random, no idling, plus a completely filled store that overflows
		// and whose final bar is itself dropped.
		idle_pct = 0;
		queue_random_mix(60);
		queue_full_basin(3);
		queue_random_mix(10);
		drain_phase();

		// Random, sender idle most of the time.
		idle_pct = 80;
		queue_random_mix(50);
		drain_phase();

		// Random, no idling: results cannot be held off, so drive flat out.
		idle_pct = 0;
		queue_random_mix(40);
		drain_phase();

		// Random, moderate sender idling.
		idle_pct = 34;
		queue_random_mix(50);
		drain_phase();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			sb.flag_mismatch($sformatf("%0d profiles never returned a result",
				sb.pending()));

		$display("covered %0d bar words in %0d profiles, %0d with dropped bars",
			words_taken, sb.profiles_checked, sb.overflow_profiles);
		$display("longest profile %0d bars, %0d cycles, %0d mismatches",
			sb.longest_profile, cycle_count, sb.errors);
		if (sb.errors == 0)
			$display("** trapped_water_total_unit: PASSED **");
		else
			$display("** trapped_water_total_unit: FAILED **");
		$finish;
	end

endmodule
